// ----- hdl/smvig_pkg.sv -----
// Shared constants, types and codes for the UV sphere mesh element generator.
package smvig_pkg;

   localparam int MAX_RESOLUTION_DEF      = 64;
   localparam int ANGLE_BITS_DEF          = 16;
   localparam int COORD_FRACTION_BITS_DEF = 14;

   localparam logic [6:0]  RESOLUTION_RESET = 7'd10;
   localparam logic [13:0] HALF_STEP_RESET  = 14'd1638;

   localparam logic [1:0] CSR_RESOLUTION = 2'd0;
   localparam logic [1:0] CSR_HALF_STEP  = 2'd1;

   localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30    = 31'd1073741824;

   localparam int TAYLOR_TERMS = 8;
   localparam int TERM_STAGES  = 3;
   localparam int TRIG_LATENCY = 2 + TAYLOR_TERMS * TERM_STAGES + 1;

   typedef struct packed {
      logic        valid;
      logic        mode;
      logic        ok;
      logic        north;
      logic        south;
      logic [12:0] first;
      logic [12:0] second;
   } sideband_type;

endpackage

// ----- hdl/smvig_term.sv -----
// One Taylor series term: multiply by x squared, divide by a constant, accumulate.
module smvig_term #(
   parameter int DIVISOR = 2,
   parameter bit NEGATE  = 1'b1
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [31:0]        term_in,
   input  logic [31:0]        x2_in,
   input  logic signed [35:0] sum_in,
   output logic [31:0]        term_out,
   output logic [31:0]        x2_out,
   output logic signed [35:0] sum_out
);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
   localparam logic [31:0] DIV_C = 32'(DIVISOR);

   logic [63:0]        a_prod_ff;
   logic [31:0]        a_x2_ff;
   logic signed [35:0] a_sum_ff;
   logic [31:0]        b_v_ff;
   logic [63:0]        b_m_ff;
   logic [31:0]        b_x2_ff;
   logic signed [35:0] b_sum_ff;
   logic [31:0]        c_term_ff;
   logic [31:0]        c_x2_ff;
   logic signed [35:0] c_sum_ff;

   logic [31:0]        v_in;
   logic [31:0]        q0;
   logic [31:0]        rem;
   logic [31:0]        q_in;
   logic signed [35:0] sum_in_next;

   always_comb begin
      v_in = a_prod_ff[61:30];
      q0   = b_m_ff[63:32];
      rem  = b_v_ff - 32'(q0 * DIV_C);
      q_in = (rem >= DIV_C) ? q0 + 32'd1 : q0;
      if (NEGATE) begin
         sum_in_next = b_sum_ff - $signed({4'b0000, q_in});
      end else begin
         sum_in_next = b_sum_ff + $signed({4'b0000, q_in});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_prod_ff <= 64'(term_in) * 64'(x2_in);
         a_x2_ff   <= x2_in;
         a_sum_ff  <= sum_in;
         b_v_ff    <= v_in;
         b_m_ff    <= 64'(v_in) * 64'(RECIP);
         b_x2_ff   <= a_x2_ff;
         b_sum_ff  <= a_sum_ff;
         c_term_ff <= q_in;
         c_x2_ff   <= b_x2_ff;
         c_sum_ff  <= sum_in_next;
      end
   end

   assign term_out = c_term_ff;
   assign x2_out   = c_x2_ff;
   assign sum_out  = c_sum_ff;
endmodule

// ----- hdl/smvig_trig.sv -----
// Pipelined fixed-point sine and cosine in Q30 from a turn-unit angle.
module smvig_trig #(
   parameter int ANGLE_BITS = smvig_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] angle_in,
   output logic signed [31:0]    sin_out,
   output logic signed [31:0]    cos_out
);
   import smvig_pkg::*;

   localparam int QD = TAYLOR_TERMS * TERM_STAGES;

   logic [31:0]        turn;
   logic [63:0]        x_prod;
   logic [61:0]        sq;
   logic [30:0]        x1_ff;
   logic [1:0]         q1_ff;
   logic [30:0]        x_ff;
   logic [31:0]        x2_ff;
   logic [1:0]         q2_ff;
   logic [1:0]         q_d_ff [QD];
   logic signed [35:0] sd_ff [TERM_STAGES];

   logic [31:0]        s_term [TAYLOR_TERMS];
   logic [31:0]        s_x2   [TAYLOR_TERMS];
   logic signed [35:0] s_sum  [TAYLOR_TERMS];
   logic [31:0]        c_term [TAYLOR_TERMS+1];
   logic [31:0]        c_x2   [TAYLOR_TERMS+1];
   logic signed [35:0] c_sum  [TAYLOR_TERMS+1];

   logic signed [35:0] s_fin;
   logic signed [35:0] c_fin;
   logic signed [31:0] s_cl;
   logic signed [31:0] c_cl;
   logic signed [31:0] sin_in;
   logic signed [31:0] cos_in;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   assign turn   = 32'(angle_in) << (32 - ANGLE_BITS);
   assign x_prod = 64'(turn[29:0]) * 64'(PIHALF_Q30);
   assign sq     = 62'(x1_ff) * 62'(x1_ff);

   assign s_term[0] = 32'(x_ff);
   assign s_x2[0]   = x2_ff;
   assign s_sum[0]  = 36'(x_ff);
   assign c_term[0] = 32'(ONE_Q30);
   assign c_x2[0]   = x2_ff;
   assign c_sum[0]  = 36'(ONE_Q30);

   for (genvar k = 1; k < TAYLOR_TERMS; k++) begin : g_sin
      smvig_term #(.DIVISOR((2 * k) * (2 * k + 1)), .NEGATE(k % 2 == 1)) u_term (
         .clock    (clock),
         .enable   (enable),
         .term_in  (s_term[k-1]),
         .x2_in    (s_x2[k-1]),
         .sum_in   (s_sum[k-1]),
         .term_out (s_term[k]),
         .x2_out   (s_x2[k]),
         .sum_out  (s_sum[k])
      );
   end

   for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_cos
      smvig_term #(.DIVISOR((2 * k - 1) * (2 * k)), .NEGATE(k % 2 == 1)) u_term (
         .clock    (clock),
         .enable   (enable),
         .term_in  (c_term[k-1]),
         .x2_in    (c_x2[k-1]),
         .sum_in   (c_sum[k-1]),
         .term_out (c_term[k]),
         .x2_out   (c_x2[k]),
         .sum_out  (c_sum[k])
      );
   end

   always_comb begin
      s_fin = sd_ff[TERM_STAGES-1];
      c_fin = c_sum[TAYLOR_TERMS];
      if (s_fin < 36'sd0) begin
         s_cl = 32'sd0;
      end else if (s_fin > 36'(ONE_Q30)) begin
         s_cl = 32'(ONE_Q30);
      end else begin
         s_cl = 32'(s_fin);
      end
      if (c_fin < 36'sd0) begin
         c_cl = 32'sd0;
      end else if (c_fin > 36'(ONE_Q30)) begin
         c_cl = 32'(ONE_Q30);
      end else begin
         c_cl = 32'(c_fin);
      end
      case (q_d_ff[QD-1])
         2'd0: begin
            sin_in = s_cl;
            cos_in = c_cl;
         end
         2'd1: begin
            sin_in = c_cl;
            cos_in = -s_cl;
         end
         2'd2: begin
            sin_in = -s_cl;
            cos_in = -c_cl;
         end
         default: begin
            sin_in = -c_cl;
            cos_in = s_cl;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff   <= x_prod[60:30];
         q1_ff   <= turn[31:30];
         x_ff    <= x1_ff;
         x2_ff   <= sq[61:30];
         q2_ff   <= q1_ff;
         q_d_ff[0] <= q2_ff;
         for (int i = 1; i < QD; i++) begin
            q_d_ff[i] <= q_d_ff[i-1];
         end
         sd_ff[0] <= s_sum[TAYLOR_TERMS-1];
         for (int i = 1; i < TERM_STAGES; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule

// ----- hdl/sphere_mesh_vertex_index_gen.sv -----
// Top level of the UV sphere mesh element generator.
// Each request beat on the req_ channel carries a mode, a column and a row.
// Mode 0 returns one vertex of a unit sphere in Q1.14 together with its slot
// address; mode 1 returns the triangle-strip index pair for a strip and position.
// Each request gives exactly one response beat on the rsp_ channel, in order.
// The csr_ channel writes the resolution and the half latitude step; it is
// always ready and should only be used while no request is in flight.
// One request is accepted every cycle while no response beat is stalled; most
// of the latency is the Taylor series chain of the two sine and cosine units,
// three stages per term over eight terms.
// While a response beat waits on a stalled receiver, the whole pipeline holds and
// req_ready falls in the same cycle, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the register defaults:
// resolution 10 and half step 1638.
module sphere_mesh_vertex_index_gen #(
   parameter int MAX_RESOLUTION      = smvig_pkg::MAX_RESOLUTION_DEF,
   parameter int ANGLE_BITS          = smvig_pkg::ANGLE_BITS_DEF,
   parameter int COORD_FRACTION_BITS = smvig_pkg::COORD_FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [5:0]         req_column,
   input  logic [6:0]         req_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic [12:0]        rsp_first_index,
   output logic [12:0]        rsp_second_index,
   output logic               rsp_in_range,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [13:0]        csr_wdata
);
   import smvig_pkg::*;

   localparam logic [8:0]  MAX_RES_C = 9'(MAX_RESOLUTION);
   localparam int          SH_Y      = 30 - COORD_FRACTION_BITS;
   localparam int          SH_P      = 60 - COORD_FRACTION_BITS;
   localparam logic [31:0] HALF_Y    = (32'd1 << SH_Y) >> 1;
   localparam logic [63:0] HALF_P    = (64'd1 << SH_P) >> 1;
   localparam logic [15:0] POLE_POS  = 16'(64'd1 << COORD_FRACTION_BITS);
   localparam logic [15:0] POLE_NEG  = 16'd0 - POLE_POS;

   logic [6:0]  resolution_ff;
   logic [13:0] half_step_ff;

   logic        adv;
   logic [6:0]  res_c;
   logic [8:0]  res_p2;
   logic        ok_in;
   logic        last_strip;
   logic [15:0] first_full;
   logic [15:0] second_full;
   logic [31:0] phi_prod;
   logic [31:0] theta_prod;
   sideband_type s1_sb_in;

   sideband_type          s1_sb_ff;
   logic [ANGLE_BITS-1:0] phi_ff;
   logic [ANGLE_BITS-1:0] theta_ff;
   sideband_type          sb_d_ff [TRIG_LATENCY];

   logic signed [31:0] sin_phi;
   logic signed [31:0] cos_phi;
   logic signed [31:0] sin_theta;
   logic signed [31:0] cos_theta;

   logic [30:0] mag_sp;
   logic [30:0] mag_cp;
   logic [30:0] mag_st;
   logic [30:0] mag_ct;
   logic [31:0] py_round;
   logic [15:0] py_in;

   sideband_type sb_b1_ff;
   logic [61:0]  prod_x_ff;
   logic [61:0]  prod_z_ff;
   logic         neg_x_ff;
   logic         neg_z_ff;
   logic [15:0]  py_ff;

   logic [63:0]  px_round;
   logic [63:0]  pz_round;
   logic [15:0]  px_ring;
   logic [15:0]  pz_ring;

   logic         rsp_valid_in;
   logic [15:0]  rsp_pos_x_in;
   logic [15:0]  rsp_pos_y_in;
   logic [15:0]  rsp_pos_z_in;
   logic [12:0]  rsp_first_in;
   logic [12:0]  rsp_second_in;
   logic         rsp_in_range_in;

   logic         rsp_valid_ff;
   logic [15:0]  rsp_pos_x_ff;
   logic [15:0]  rsp_pos_y_ff;
   logic [15:0]  rsp_pos_z_ff;
   logic [12:0]  rsp_first_ff;
   logic [12:0]  rsp_second_ff;
   logic         rsp_in_range_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= RESOLUTION_RESET;
         half_step_ff  <= HALF_STEP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RESOLUTION: resolution_ff <= csr_wdata[6:0];
            CSR_HALF_STEP:  half_step_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front stage: range check, slot addresses and the two angles.
   always_comb begin
      res_c       = (9'(resolution_ff) > MAX_RES_C) ? MAX_RES_C[6:0] : resolution_ff;
      res_p2      = 9'(res_c) + 9'd2;
      ok_in       = ({1'b0, req_column} < res_c) && (9'(req_row) < res_p2);
      last_strip  = (({1'b0, req_column} + 7'd1) == res_c);
      first_full  = 16'(16'(req_column) * 16'(res_p2)) + 16'(req_row);
      second_full = last_strip ? 16'(req_row) : first_full + 16'(res_p2);
      phi_prod    = 32'(8'({req_row, 1'b0} - 8'd1)) * 32'(half_step_ff);
      theta_prod  = 32'({req_column, 2'b10}) * 32'(half_step_ff);

      s1_sb_in.valid  = req_valid;
      s1_sb_in.mode   = req_mode;
      s1_sb_in.ok     = ok_in;
      s1_sb_in.north  = (req_row == 7'd0);
      s1_sb_in.south  = (9'(req_row) == res_p2 - 9'd1);
      s1_sb_in.first  = first_full[12:0];
      s1_sb_in.second = req_mode ? second_full[12:0] : 13'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_sb_ff <= '0;
         for (int i = 0; i < TRIG_LATENCY; i++) begin
            sb_d_ff[i] <= '0;
         end
      end else if (adv) begin
         s1_sb_ff   <= s1_sb_in;
         sb_d_ff[0] <= s1_sb_ff;
         for (int i = 1; i < TRIG_LATENCY; i++) begin
            sb_d_ff[i] <= sb_d_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phi_ff   <= phi_prod[ANGLE_BITS-1:0];
         theta_ff <= theta_prod[ANGLE_BITS-1:0];
      end
   end

   smvig_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_phi (
      .clock    (clock),
      .enable   (adv),
      .angle_in (phi_ff),
      .sin_out  (sin_phi),
      .cos_out  (cos_phi)
   );

   smvig_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_theta (
      .clock    (clock),
      .enable   (adv),
      .angle_in (theta_ff),
      .sin_out  (sin_theta),
      .cos_out  (cos_theta)
   );

   // Back stage one: magnitudes, products and rounding of y.
   always_comb begin
      mag_sp   = sin_phi[31]   ? 31'(-sin_phi)   : sin_phi[30:0];
      mag_cp   = cos_phi[31]   ? 31'(-cos_phi)   : cos_phi[30:0];
      mag_st   = sin_theta[31] ? 31'(-sin_theta) : sin_theta[30:0];
      mag_ct   = cos_theta[31] ? 31'(-cos_theta) : cos_theta[30:0];
      py_round = (32'(mag_cp) + HALF_Y) >> SH_Y;
      py_in    = cos_phi[31] ? 16'(32'd0 - py_round) : py_round[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_b1_ff <= '0;
      end else if (adv) begin
         sb_b1_ff <= sb_d_ff[TRIG_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= 62'(mag_sp) * 62'(mag_ct);
         prod_z_ff <= 62'(mag_sp) * 62'(mag_st);
         neg_x_ff  <= sin_phi[31] ^ cos_theta[31];
         neg_z_ff  <= sin_phi[31] ^ sin_theta[31];
         py_ff     <= py_in;
      end
   end

   // Back stage two: rounding of x and z, and selection of the response.
   always_comb begin
      px_round = (64'(prod_x_ff) + HALF_P) >> SH_P;
      pz_round = (64'(prod_z_ff) + HALF_P) >> SH_P;
      px_ring  = neg_x_ff ? 16'(64'd0 - px_round) : px_round[15:0];
      pz_ring  = neg_z_ff ? 16'(64'd0 - pz_round) : pz_round[15:0];

      rsp_valid_in    = sb_b1_ff.valid;
      rsp_pos_x_in    = 16'd0;
      rsp_pos_y_in    = 16'd0;
      rsp_pos_z_in    = 16'd0;
      rsp_first_in    = 13'd0;
      rsp_second_in   = 13'd0;
      rsp_in_range_in = 1'b0;
      if (sb_b1_ff.ok) begin
         rsp_in_range_in = 1'b1;
         rsp_first_in    = sb_b1_ff.first;
         rsp_second_in   = sb_b1_ff.second;
         if (!sb_b1_ff.mode) begin
            if (sb_b1_ff.north) begin
               rsp_pos_y_in = POLE_POS;
            end else if (sb_b1_ff.south) begin
               rsp_pos_y_in = POLE_NEG;
            end else begin
               rsp_pos_x_in = px_ring;
               rsp_pos_y_in = py_ff;
               rsp_pos_z_in = pz_ring;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pos_x_ff    <= rsp_pos_x_in;
         rsp_pos_y_ff    <= rsp_pos_y_in;
         rsp_pos_z_ff    <= rsp_pos_z_in;
         rsp_first_ff    <= rsp_first_in;
         rsp_second_ff   <= rsp_second_in;
         rsp_in_range_ff <= rsp_in_range_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_pos_z        = rsp_pos_z_ff;
   assign rsp_first_index  = rsp_first_ff;
   assign rsp_second_index = rsp_second_ff;
   assign rsp_in_range     = rsp_in_range_ff;

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_in_range_ff |->
         rsp_pos_x_ff == 16'd0 && rsp_pos_y_ff == 16'd0 && rsp_pos_z_ff == 16'd0 &&
         rsp_first_ff == 13'd0 && rsp_second_ff == 13'd0)
      else $error("out-of-range response carries non-zero fields");

   a_strip_has_no_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_second_ff != 13'd0 |->
         rsp_pos_x_ff == 16'd0 && rsp_pos_y_ff == 16'd0 && rsp_pos_z_ff == 16'd0)
      else $error("strip index response carries a position");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sb_d_ff[TRIG_LATENCY-1]) && $stable(sb_b1_ff))
      else $error("pipeline moved while the response was stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !sb_b1_ff.valid && !s1_sb_ff.valid)
      else $error("pipeline not empty after reset");
endmodule
